/* rtl/core/tqof_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tqof_pkg
// Shared types and constants of the trajectory quartile outlier filter.
// ----------------------------------------------------------------------------
package tqof_pkg;

    localparam int CNT_W   = 7;
    localparam int SCALE_W = 4;
    localparam int MINR_W  = 7;
    localparam int CFG_W   = 7;
    localparam int NUM_COLS = 8;
    localparam int NUM_STEP = 2;

    localparam logic CFG_IQR_SCALE = 1'b0;
    localparam logic CFG_MIN_ROWS  = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;
    localparam logic [MINR_W-1:0]  MINR_RESET  = 7'd10;

    typedef struct packed {
        logic             wr_en;
        logic [CNT_W-1:0] wr_idx;
        logic             sweep;
        logic             first;
        logic             last;
        logic             check;
        logic             band;
        logic             clr;
        logic [CNT_W-1:0] rd_i;
        logic [CNT_W-1:0] rd_j;
    } t_lane_ctl;

endpackage

`default_nettype wire

/* rtl/core/tqof_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tqof_lane
// One column lane: stores the column (or its absolute steps), finds the
// quartiles by rank counting, builds the band and flags outliers.
// ----------------------------------------------------------------------------
module tqof_lane #(
    parameter int MAX_POINTS  = 64,
    parameter int VALUE_WIDTH = 32,
    parameter bit STEP        = 1'b0
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tqof_pkg::t_lane_ctl             i_ctl,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_wr_val,
    input  wire logic [tqof_pkg::CNT_W-1:0]      i_nv,
    input  wire logic [tqof_pkg::SCALE_W-1:0]    i_scale,
    output logic [MAX_POINTS-1:0]                o_reject
);
    import tqof_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DW = VALUE_WIDTH + 2;
    localparam int HW = DW + SCALE_W + 1;

    logic signed [DW-1:0] r_mem [MAX_POINTS];
    logic signed [DW-1:0] r_prev;
    logic signed [DW-1:0] r_a;
    logic signed [DW-1:0] r_b;
    logic signed [DW-1:0] r_q1;
    logic signed [DW-1:0] r_med;
    logic signed [DW-1:0] r_q3;
    logic signed [HW-1:0] r_half;
    logic [CNT_W-1:0]     r_cl;
    logic [CNT_W-1:0]     r_ce;
    logic                 r_t_sweep;
    logic                 r_t_first;
    logic                 r_t_last;
    logic                 r_t_check;
    logic [CNT_W-1:0]     r_t_i;
    logic [CNT_W-1:0]     r_t_j;
    logic [MAX_POINTS-1:0] r_rej;

    logic signed [DW-1:0] wr_ext;
    logic signed [DW-1:0] step_d;
    logic signed [DW-1:0] step_abs;
    logic [CNT_W-1:0]     wr_dec;
    logic [CNT_W-1:0]     m;
    logic [CNT_W-1:0]     p1;
    logic [CNT_W-1:0]     p2;
    logic [CNT_W-1:0]     p3;
    logic [CNT_W+1:0]     m3;
    logic                 lt;
    logic                 eq;
    logic [CNT_W-1:0]     n_cl;
    logic [CNT_W-1:0]     n_ce;
    logic [CNT_W-1:0]     hi;
    logic signed [DW:0]   qdiff;
    logic signed [HW-1:0] d;
    logic                 inside_band;
    logic [CNT_W-1:0]     rej_pos;

    assign wr_ext   = DW'(i_wr_val);
    assign step_d   = wr_ext - r_prev;
    assign step_abs = step_d[DW-1] ? -step_d : step_d;
    assign wr_dec   = i_ctl.wr_idx - CNT_W'(1);

    assign m  = STEP ? ((i_nv == '0) ? '0 : i_nv - CNT_W'(1)) : i_nv;
    assign m3 = (CNT_W+2)'(m) * (CNT_W+2)'(3);
    assign p1 = m >> 2;
    assign p2 = m >> 1;
    assign p3 = CNT_W'(m3 >> 2);

    assign lt   = (r_b < r_a) && (r_t_j < m);
    assign eq   = (r_b == r_a) && (r_t_j < m);
    assign n_cl = (r_t_first ? '0 : r_cl) + CNT_W'(lt);
    assign n_ce = (r_t_first ? '0 : r_ce) + CNT_W'(eq);
    assign hi   = n_cl + n_ce;

    assign qdiff       = (DW+1)'(r_q3) - (DW+1)'(r_q1);
    assign d           = HW'(r_a) - HW'(r_med);
    assign inside_band = (d > -r_half) && (d < r_half);
    assign rej_pos     = STEP ? r_t_i + CNT_W'(1) : r_t_i;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_prev <= wr_ext;
            if (STEP) begin
                if (i_ctl.wr_idx != '0) begin
                    r_mem[wr_dec[AW-1:0]] <= step_abs;
                end
            end else begin
                r_mem[i_ctl.wr_idx[AW-1:0]] <= wr_ext;
            end
        end
        r_a <= r_mem[i_ctl.rd_i[AW-1:0]];
        r_b <= r_mem[i_ctl.rd_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_t_first <= i_ctl.first;
        r_t_last  <= i_ctl.last;
        r_t_i     <= i_ctl.rd_i;
        r_t_j     <= i_ctl.rd_j;
        if (r_t_sweep) begin
            r_cl <= n_cl;
            r_ce <= n_ce;
            if (r_t_last && (r_t_i < m)) begin
                if ((n_cl <= p1) && (p1 < hi)) begin
                    r_q1 <= r_a;
                end
                if ((n_cl <= p2) && (p2 < hi)) begin
                    r_med <= r_a;
                end
                if ((n_cl <= p3) && (p3 < hi)) begin
                    r_q3 <= r_a;
                end
            end
        end
        if (i_ctl.band) begin
            r_half <= HW'(signed'({1'b0, i_scale})) * HW'(qdiff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_sweep <= 1'b0;
            r_t_check <= 1'b0;
            r_rej     <= '0;
        end else begin
            r_t_sweep <= i_ctl.sweep;
            r_t_check <= i_ctl.check;
            if (i_ctl.clr) begin
                r_rej <= '0;
            end else if (r_t_check && (r_t_i < m) && !inside_band) begin
                r_rej[rej_pos[AW-1:0]] <= 1'b1;
            end
        end
    end

    assign o_reject = r_rej;

endmodule

`default_nettype wire

/* rtl/core/trajectory_quartile_outlier_filter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trajectory_quartile_outlier_filter_unit
// Loads a track, rejects interquartile-range outliers over eight column
// lanes and emits one keep verdict per loaded point.
// ----------------------------------------------------------------------------
// channel   | ports                                  | transfer
// input     | i_start, o_busy, i_point_valid..last   | i_start & !o_busy
// result    | o_strobe, o_point_index..o_last_result | o_strobe, one cycle
// config    | i_cfg_we, i_cfg_idx, i_cfg_data        | i_cfg_we
//
// Points load one per cycle. After the last point: a decision state, then
// rank counting over nv*nv pairs (one pair per cycle, all lanes in parallel),
// flush, band and per-point check states, then one verdict per cycle for every
// loaded point. A short or empty track skips straight to the verdicts.
// Reset is synchronous; the receiver cannot stall the results.
// ----------------------------------------------------------------------------
module trajectory_quartile_outlier_filter_unit #(
    parameter int MAX_POINTS  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic                        i_point_valid,
    input  wire logic signed [31:0]          i_pos_x,
    input  wire logic signed [31:0]          i_pos_y,
    input  wire logic signed [31:0]          i_size_x,
    input  wire logic signed [31:0]          i_size_y,
    input  wire logic signed [31:0]          i_err_x,
    input  wire logic signed [31:0]          i_err_y,
    input  wire logic signed [31:0]          i_background,
    input  wire logic signed [31:0]          i_signal_level,
    input  wire logic                        i_last_point,
    output logic                             o_strobe,
    output logic [5:0]                       o_point_index,
    output logic                             o_keep,
    output logic                             o_short_track,
    output logic                             o_last_result,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [tqof_pkg::CFG_W-1:0]  i_cfg_data
);
    import tqof_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [2:0] {
        S_LOAD, S_DECIDE, S_SWEEP, S_FLUSH_S, S_BAND, S_CHECK, S_FLUSH_C, S_EMIT
    } t_state;

    t_state                r_state;
    logic [SCALE_W-1:0]    r_scale;
    logic [MINR_W-1:0]     r_min_rows;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_nv;
    logic [MAX_POINTS-1:0] r_vflags;
    logic                  r_short;
    logic [CNT_W-1:0]      r_i;
    logic [CNT_W-1:0]      r_j;
    logic [CNT_W-1:0]      r_k;
    logic                  r_strobe;
    logic [5:0]            r_index;
    logic                  r_keep;
    logic                  r_last;

    t_lane_ctl             lane_ctl;
    logic                  accept;
    logic                  room;
    logic [CNT_W-1:0]      nv_m1;
    logic [CNT_W-1:0]      cnt_m1;
    logic signed [31:0]    col_in [NUM_COLS];
    logic [MAX_POINTS-1:0] lane_rej [NUM_COLS];
    logic [MAX_POINTS-1:0] rej_any;

    assign accept = i_start && (r_state == S_LOAD);
    assign room   = r_cnt < CNT_W'(MAX_POINTS);
    assign nv_m1  = r_nv - CNT_W'(1);
    assign cnt_m1 = r_cnt - CNT_W'(1);

    assign col_in[0] = i_pos_x;
    assign col_in[1] = i_pos_y;
    assign col_in[2] = i_size_x;
    assign col_in[3] = i_size_y;
    assign col_in[4] = i_err_x;
    assign col_in[5] = i_err_y;
    assign col_in[6] = i_background;
    assign col_in[7] = i_signal_level;

    always_comb begin
        lane_ctl        = '0;
        lane_ctl.wr_en  = accept && room && i_point_valid;
        lane_ctl.wr_idx = r_nv;
        lane_ctl.sweep  = (r_state == S_SWEEP);
        lane_ctl.first  = (r_j == '0);
        lane_ctl.last   = (r_j == nv_m1);
        lane_ctl.check  = (r_state == S_CHECK);
        lane_ctl.band   = (r_state == S_BAND);
        lane_ctl.clr    = (r_state == S_EMIT) && (r_i == cnt_m1);
        lane_ctl.rd_i   = (r_state == S_CHECK) ? r_k : r_i;
        lane_ctl.rd_j   = r_j;
    end

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
        logic [63:0]                    wide;
        logic signed [VALUE_WIDTH-1:0]  val;
        assign wide = {{32{col_in[c][31]}}, col_in[c]};
        assign val  = wide[VALUE_WIDTH-1:0];
        tqof_lane #(
            .MAX_POINTS  (MAX_POINTS),
            .VALUE_WIDTH (VALUE_WIDTH),
            .STEP        (c < NUM_STEP)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_wr_val (val),
            .i_nv     (r_nv),
            .i_scale  (r_scale),
            .o_reject (lane_rej[c])
        );
    end

    always_comb begin
        rej_any = '0;
        for (int c = 0; c < NUM_COLS; c++) begin
            rej_any = rej_any | lane_rej[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_RESET;
            r_min_rows <= MINR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IQR_SCALE: r_scale    <= i_cfg_data[SCALE_W-1:0];
                CFG_MIN_ROWS:  r_min_rows <= i_cfg_data[MINR_W-1:0];
                default:       r_scale    <= r_scale;
            endcase
        end
    end

    // r_i doubles as the verdict counter, r_k as the valid ordinal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_nv     <= '0;
            r_vflags <= '0;
            r_short  <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
            r_index  <= '0;
            r_keep   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_EMIT);
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (room) begin
                            r_vflags[r_cnt[AW-1:0]] <= i_point_valid;
                            r_cnt <= r_cnt + CNT_W'(1);
                            r_nv  <= r_nv + CNT_W'(i_point_valid);
                        end
                        if (i_last_point) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_short <= r_nv < r_min_rows;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_k     <= '0;
                    if ((r_nv < r_min_rows) || (r_nv == '0)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_j == nv_m1) begin
                        r_j <= '0;
                        r_i <= r_i + CNT_W'(1);
                        if (r_i == nv_m1) begin
                            r_state <= S_FLUSH_S;
                        end
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                    end
                end
                S_FLUSH_S: r_state <= S_BAND;
                S_BAND: begin
                    r_k     <= '0;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_k == nv_m1) begin
                        r_state <= S_FLUSH_C;
                    end
                    r_k <= r_k + CNT_W'(1);
                end
                S_FLUSH_C: begin
                    r_i     <= '0;
                    r_k     <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_index  <= r_i[5:0];
                    r_keep   <= r_vflags[r_i[AW-1:0]] && !rej_any[r_k[AW-1:0]];
                    r_last   <= (r_i == cnt_m1);
                    if (r_vflags[r_i[AW-1:0]]) begin
                        r_k <= r_k + CNT_W'(1);
                    end
                    if (r_i == cnt_m1) begin
                        r_cnt    <= '0;
                        r_nv     <= '0;
                        r_vflags <= '0;
                        r_i      <= '0;
                        r_state  <= S_LOAD;
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_busy        = (r_state != S_LOAD);
    assign o_strobe      = r_strobe;
    assign o_point_index = r_index;
    assign o_keep        = r_keep;
    assign o_short_track = r_short;
    assign o_last_result = r_last;

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_point) |=> o_busy)
        else $error("run did not start after last point");

    a_nv_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nv <= r_cnt)
        else $error("valid count above point count");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_result) |=> !o_strobe)
        else $error("verdict after final verdict");

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(r_state == S_EMIT))
        else $error("strobe outside emit phase");

endmodule

`default_nettype wire
